// ----- design/mff_pkg.sv -----
// Package for the multichannel frame FIFO: sizes, result kinds and the
// control structs passed between the controller, the lanes and the merge stage.
// No dependencies.
`default_nettype none

package mff_pkg;

    localparam int CAPACITY     = 1024;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_READ     = 64;

    function automatic int ring_of(input int cap);
        int r;
        r = 1;
        while (r < cap)
            r = r << 1;
        return r;
    endfunction

    localparam int RING = ring_of(CAPACITY);
    localparam int AW   = (RING > 1) ? $clog2(RING) : 1;
    localparam int LW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int CW  = 3;
    localparam int FW  = 13;
    localparam int RQW = 7;
    localparam int AVW = 11;
    localparam int SW  = 32;
    localparam int PW  = 32;

    typedef logic [SW-1:0] sample_t;

    typedef enum logic [2:0] {
        KIND_ACCEPT  = 3'd0,
        KIND_DROP    = 3'd1,
        KIND_READ    = 3'd2,
        KIND_EMPTY   = 3'd3,
        KIND_INVALID = 3'd4
    } kind_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [AW-1:0] rd_addr;
        logic [CW-1:0] src;
        logic [CW-1:0] lane_count;
    } lane_ctl_t;

    typedef struct packed {
        logic           load;
        kind_t          kind;
        logic           last;
        logic [AVW-1:0] avail;
        logic [PW-1:0]  dropped;
        logic [PW-1:0]  rtotal;
    } emit_t;

endpackage

`default_nettype wire

// ----- design/mff_in_if.sv -----
// Input channel of the multichannel frame FIFO: valid/ready plus one item.
// Depends on mff_pkg.
`default_nettype none

interface mff_in_if;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic                   block_start;
    logic [mff_pkg::FW-1:0] block_frames;
    logic [mff_pkg::CW-1:0] src_channels;
    mff_pkg::sample_t       in_sample_0;
    mff_pkg::sample_t       in_sample_1;
    mff_pkg::sample_t       in_sample_2;
    mff_pkg::sample_t       in_sample_3;
    logic [mff_pkg::RQW-1:0] max_frames;

    modport source (
        output valid, cmd, block_start, block_frames, src_channels,
               in_sample_0, in_sample_1, in_sample_2, in_sample_3, max_frames,
        input  ready
    );

    modport sink (
        input  valid, cmd, block_start, block_frames, src_channels,
               in_sample_0, in_sample_1, in_sample_2, in_sample_3, max_frames,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/mff_out_if.sv -----
// Output channel of the multichannel frame FIFO: valid/ready plus one result item.
// Depends on mff_pkg.
`default_nettype none

interface mff_out_if;
    logic                    valid;
    logic                    ready;
    mff_pkg::kind_t          kind;
    mff_pkg::sample_t        out_sample_0;
    mff_pkg::sample_t        out_sample_1;
    mff_pkg::sample_t        out_sample_2;
    mff_pkg::sample_t        out_sample_3;
    logic                    last;
    logic [mff_pkg::AVW-1:0] available_frames;
    logic [mff_pkg::PW-1:0]  dropped_total;
    logic [mff_pkg::PW-1:0]  read_total;

    modport source (
        output valid, kind, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
               last, available_frames, dropped_total, read_total,
        input  ready
    );

    modport sink (
        input  valid, kind, out_sample_0, out_sample_1, out_sample_2, out_sample_3,
               last, available_frames, dropped_total, read_total,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/mff_lane.sv -----
// One channel lane: a ring memory of sample words with channel fill-up on write
// and a registered, masked read. Depends on mff_pkg.
`default_nettype none

module mff_lane (
    input  wire logic                   clk,
    input  wire logic [mff_pkg::LW-1:0] lane_idx,
    input  wire mff_pkg::lane_ctl_t     lane_ctl,
    input  wire mff_pkg::sample_t       samples [mff_pkg::MAX_CHANNELS],
    output mff_pkg::sample_t            q
);

    mff_pkg::sample_t            mem [mff_pkg::RING];
    mff_pkg::sample_t            q_reg;
    logic [mff_pkg::CW-1:0]      idx_w;
    logic [mff_pkg::CW-1:0]      sel_w;
    logic                        lane_on;

    always_comb
    begin
        idx_w = mff_pkg::CW'(lane_idx);
        if (idx_w < lane_ctl.src)
            sel_w = idx_w;
        else
            sel_w = lane_ctl.src - mff_pkg::CW'(1);
        lane_on = idx_w < lane_ctl.lane_count;
    end

    always_ff @(posedge clk)
    begin
        if (lane_ctl.wr_en)
            mem[lane_ctl.wr_addr] <= samples[sel_w[mff_pkg::LW-1:0]];
        q_reg <= mem[lane_ctl.rd_addr];
    end

    assign q = lane_on ? q_reg : '0;

endmodule

`default_nettype wire

// ----- design/mff_merge.sv -----
// Merge stage: combines the lane read words with the controller's result fields
// into the output register. Depends on mff_pkg and mff_out_if.
`default_nettype none

module mff_merge (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mff_pkg::emit_t     emit,
    input  wire mff_pkg::sample_t   lane_q [mff_pkg::MAX_CHANNELS],
    mff_out_if.source               result_out,
    output logic                    slot_free
);

    logic                    valid_reg;
    mff_pkg::kind_t          kind_reg;
    logic                    last_reg;
    logic [mff_pkg::AVW-1:0] avail_reg;
    logic [mff_pkg::PW-1:0]  dropped_reg;
    logic [mff_pkg::PW-1:0]  rtotal_reg;
    mff_pkg::sample_t        smp_reg [mff_pkg::MAX_CHANNELS];

    assign slot_free = !valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= emit.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && emit.load)
        begin
            kind_reg    <= emit.kind;
            last_reg    <= emit.last;
            avail_reg   <= emit.avail;
            dropped_reg <= emit.dropped;
            rtotal_reg  <= emit.rtotal;
            for (int c = 0; c < mff_pkg::MAX_CHANNELS; c++)
            begin
                smp_reg[c] <= (emit.kind == mff_pkg::KIND_READ) ? lane_q[c] : '0;
            end
        end
    end

    assign result_out.valid            = valid_reg;
    assign result_out.kind             = kind_reg;
    assign result_out.last             = last_reg;
    assign result_out.available_frames = avail_reg;
    assign result_out.dropped_total    = dropped_reg;
    assign result_out.read_total       = rtotal_reg;
    assign result_out.out_sample_0     = smp_reg[0];
    assign result_out.out_sample_1     = smp_reg[1];
    assign result_out.out_sample_2     = smp_reg[2];
    assign result_out.out_sample_3     = smp_reg[3];

endmodule

`default_nettype wire

// ----- design/mff_ctrl.sv -----
// Controller: block admission, ring positions, drop and read counters, read
// sequencing and lane commands. Depends on mff_pkg and mff_in_if.
`default_nettype none

module mff_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [mff_pkg::CW-1:0] cfg_wdata,
    mff_in_if.sink                      item_in,
    input  wire logic                   slot_free,
    output mff_pkg::lane_ctl_t          lane_ctl,
    output mff_pkg::emit_t              emit
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    localparam logic [mff_pkg::AW:0]    RING_W = (mff_pkg::AW + 1)'(mff_pkg::RING);
    localparam logic [mff_pkg::RQW-1:0] MAXR_W = mff_pkg::RQW'(mff_pkg::MAX_READ);
    localparam logic [mff_pkg::CW-1:0]  MAXC_W = mff_pkg::CW'(mff_pkg::MAX_CHANNELS);

    state_t                   state_reg,  state_next;
    logic [mff_pkg::CW-1:0]   chan_reg,   chan_next;
    logic [mff_pkg::PW-1:0]   commit_reg, commit_next;
    logic [mff_pkg::PW-1:0]   work_reg,   work_next;
    logic [mff_pkg::PW-1:0]   rpos_reg,   rpos_next;
    logic [mff_pkg::PW-1:0]   drop_reg,   drop_next;
    logic [mff_pkg::FW-1:0]   left_reg,   left_next;
    logic                     admit_reg,  admit_next;
    logic [mff_pkg::CW-1:0]   src_reg,    src_next;
    logic [mff_pkg::RQW-1:0]  count_reg,  count_next;

    logic                     accept;
    logic [mff_pkg::PW-1:0]   avail_cur;
    logic [mff_pkg::AW:0]     free_w;
    logic [mff_pkg::RQW-1:0]  want;
    logic [mff_pkg::PW-1:0]   n32;
    logic [mff_pkg::PW:0]     dsum;
    logic                     proceed;
    logic [mff_pkg::PW-1:0]   avail_after;

    assign item_in.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept        = item_in.valid && item_in.ready;

    always_comb
    begin
        state_next  = state_reg;
        chan_next   = chan_reg;
        commit_next = commit_reg;
        work_next   = work_reg;
        rpos_next   = rpos_reg;
        drop_next   = drop_reg;
        left_next   = left_reg;
        admit_next  = admit_reg;
        src_next    = src_reg;
        count_next  = count_reg;
        proceed     = 1'b0;

        emit.load = 1'b0;
        emit.kind = mff_pkg::KIND_INVALID;
        emit.last = 1'b1;

        lane_ctl.wr_en = 1'b0;

        avail_cur = commit_reg - rpos_reg;
        free_w    = RING_W - avail_cur[mff_pkg::AW:0];
        want      = (item_in.max_frames > MAXR_W) ? MAXR_W : item_in.max_frames;
        n32       = (mff_pkg::PW'(want) < avail_cur) ? mff_pkg::PW'(want) : avail_cur;
        dsum      = {1'b0, drop_reg} + (mff_pkg::PW + 1)'(item_in.block_frames);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item_in.cmd == mff_pkg::CMD_WRITE)
                begin
                    emit.load = 1'b1;
                    if (item_in.block_start)
                    begin
                        work_next  = commit_reg;
                        left_next  = '0;
                        admit_next = 1'b0;
                        if (item_in.src_channels == '0 || item_in.src_channels > MAXC_W
                            || item_in.block_frames == '0)
                        begin
                            emit.kind = mff_pkg::KIND_INVALID;
                        end
                        else
                        begin
                            proceed   = 1'b1;
                            src_next  = item_in.src_channels;
                            left_next = item_in.block_frames;
                            if (item_in.block_frames > mff_pkg::FW'(free_w))
                            begin
                                drop_next = dsum[mff_pkg::PW] ? '1 : dsum[mff_pkg::PW-1:0];
                            end
                            else
                            begin
                                admit_next = 1'b1;
                            end
                        end
                    end
                    else if (left_reg == '0)
                    begin
                        emit.kind = mff_pkg::KIND_INVALID;
                    end
                    else
                    begin
                        proceed = 1'b1;
                    end

                    if (proceed)
                    begin
                        left_next = left_next - mff_pkg::FW'(1);
                        if (!admit_next)
                        begin
                            emit.kind = mff_pkg::KIND_DROP;
                        end
                        else
                        begin
                            emit.kind      = mff_pkg::KIND_ACCEPT;
                            lane_ctl.wr_en = 1'b1;
                            work_next      = work_next + mff_pkg::PW'(1);
                            if (left_next == '0)
                            begin
                                commit_next = work_next;
                                admit_next  = 1'b0;
                            end
                        end
                    end
                end
                else if (accept)
                begin
                    emit.load = 1'b1;
                    if (n32 == '0)
                    begin
                        emit.kind = mff_pkg::KIND_EMPTY;
                    end
                    else
                    begin
                        emit.load  = 1'b0;
                        count_next = n32[mff_pkg::RQW-1:0];
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                if (slot_free)
                begin
                    emit.load  = 1'b1;
                    emit.kind  = mff_pkg::KIND_READ;
                    emit.last  = (count_reg == mff_pkg::RQW'(1));
                    rpos_next  = rpos_reg + mff_pkg::PW'(1);
                    count_next = count_reg - mff_pkg::RQW'(1);
                    if (count_reg == mff_pkg::RQW'(1))
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            chan_next   = cfg_wdata;
            commit_next = '0;
            work_next   = '0;
            rpos_next   = '0;
            drop_next   = '0;
            left_next   = '0;
            admit_next  = 1'b0;
            src_next    = '0;
            state_next  = ST_IDLE;
        end

        avail_after  = commit_next - rpos_next;
        emit.avail   = avail_after[mff_pkg::AVW-1:0];
        emit.dropped = drop_next;
        emit.rtotal  = rpos_next;

        lane_ctl.wr_addr = work_reg[mff_pkg::AW-1:0];
        if (item_in.block_start)
            lane_ctl.wr_addr = commit_reg[mff_pkg::AW-1:0];
        lane_ctl.rd_addr = rpos_next[mff_pkg::AW-1:0];
        lane_ctl.src     = item_in.block_start ? item_in.src_channels : src_reg;
        if (chan_reg == '0)
            lane_ctl.lane_count = mff_pkg::CW'(1);
        else if (chan_reg > MAXC_W)
            lane_ctl.lane_count = MAXC_W;
        else
            lane_ctl.lane_count = chan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            chan_reg   <= mff_pkg::CW'(1);
            commit_reg <= '0;
            work_reg   <= '0;
            rpos_reg   <= '0;
            drop_reg   <= '0;
            left_reg   <= '0;
            admit_reg  <= 1'b0;
            src_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            chan_reg   <= chan_next;
            commit_reg <= commit_next;
            work_reg   <= work_next;
            rpos_reg   <= rpos_next;
            drop_reg   <= drop_next;
            left_reg   <= left_next;
            admit_reg  <= admit_next;
            src_reg    <= src_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/multichannel_frame_fifo.sv -----
// Multichannel frame FIFO: a write block of N frames is admitted or dropped whole
// at its first frame and becomes readable when its last frame is stored; a read
// request of up to 64 frames returns one result per frame, or one empty result.
// A write item gives one result. A read request that finds n frames is first taken
// and its frame count loaded; then it gives one frame per cycle while the sink is
// ready, each lane memory reading the next frame ahead into its output register.
// The next item is taken once the controller is back in idle after the last frame
// enters the output register and the output slot is free. A result held by the
// sink stalls the input. Storage needs no clearing after reset.
// Depends on mff_pkg, mff_in_if, mff_out_if, mff_ctrl, mff_lane, mff_merge.
`default_nettype none

module multichannel_frame_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    mff_in_if.sink                      item_in,
    mff_out_if.source                   result_out,
    input  wire logic                   cfg_we,
    input  wire logic [mff_pkg::CW-1:0] cfg_wdata
);

    mff_pkg::lane_ctl_t lane_ctl;
    mff_pkg::emit_t     emit;
    logic               slot_free;
    mff_pkg::sample_t   samples [mff_pkg::MAX_CHANNELS];
    mff_pkg::sample_t   lane_q  [mff_pkg::MAX_CHANNELS];

    assign samples[0] = item_in.in_sample_0;
    assign samples[1] = item_in.in_sample_1;
    assign samples[2] = item_in.in_sample_2;
    assign samples[3] = item_in.in_sample_3;

    mff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_in   (item_in),
        .slot_free (slot_free),
        .lane_ctl  (lane_ctl),
        .emit      (emit)
    );

    for (genvar c = 0; c < mff_pkg::MAX_CHANNELS; c++)
    begin : g_lane
        mff_lane u_lane (
            .clk      (clk),
            .lane_idx (mff_pkg::LW'(c)),
            .lane_ctl (lane_ctl),
            .samples  (samples),
            .q        (lane_q[c])
        );
    end

    mff_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .lane_q     (lane_q),
        .result_out (result_out),
        .slot_free  (slot_free)
    );

endmodule

`default_nettype wire

// ----- design/mff_checker.sv -----
// Port-level checks for the multichannel frame FIFO results, and the bind that
// attaches them to the top level. Depends on mff_pkg and multichannel_frame_fifo.
`default_nettype none

module mff_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [2:0]              kind,
    input wire mff_pkg::sample_t        s0,
    input wire mff_pkg::sample_t        s1,
    input wire mff_pkg::sample_t        s2,
    input wire mff_pkg::sample_t        s3,
    input wire logic                    last,
    input wire logic [mff_pkg::AVW-1:0] avail
);

    a_quiet_samples: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != mff_pkg::KIND_READ
        |-> s0 == '0 && s1 == '0 && s2 == '0 && s3 == '0)
        else $error("non-read result carries sample data");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != mff_pkg::KIND_READ |-> last)
        else $error("non-read result without last mark");

    a_avail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> avail <= mff_pkg::AVW'(mff_pkg::RING))
        else $error("available frames exceed ring size");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
        else $error("stalled result changed");

endmodule

bind multichannel_frame_fifo mff_checker u_mff_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .kind      (result_out.kind),
    .s0        (result_out.out_sample_0),
    .s1        (result_out.out_sample_1),
    .s2        (result_out.out_sample_2),
    .s3        (result_out.out_sample_3),
    .last      (result_out.last),
    .avail     (result_out.available_frames)
);

`default_nettype wire
